FILE: hdl/rhc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the divider step for the RGB to HSV classifier.
// Used by rhc_front, rhc_cell and the top level; depends on nothing.
package rhc_pkg;

   localparam int CH_W = 8;
   localparam int HUE_FRAC_BITS = 6;
   localparam int HUE_W = 15;
   localparam int NUM_W = 17;
   localparam int HUE_Q_W = 9 + HUE_FRAC_BITS;
   localparam int CELLS = (HUE_Q_W > HUE_W) ? HUE_Q_W : HUE_W;
   localparam int DIV_W = CELLS + CH_W;

   localparam int SAT_W = 8;
   localparam int LIM_W = 9;
   localparam int CLASS_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_BITS = HUE_W + SAT_W + CH_W + CLASS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [SAT_W-1:0] SAT_LIMIT_RESET = 8'd51;
   localparam logic [LIM_W-1:0] DARK_LIMIT_RESET = 9'd77;
   localparam logic [LIM_W-1:0] BRIGHT_LIMIT_RESET = 9'd179;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_BLACK   = 4'd0,
      CLASS_WHITE   = 4'd1,
      CLASS_GRAY    = 4'd2,
      CLASS_RED     = 4'd3,
      CLASS_ORANGE  = 4'd4,
      CLASS_YELLOW  = 4'd5,
      CLASS_GREEN   = 4'd6,
      CLASS_CYAN    = 4'd7,
      CLASS_BLUE    = 4'd8,
      CLASS_MAGENTA = 4'd9
   } class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAT_LIMIT    = 2'd0,
      CSR_DARK_LIMIT   = 2'd1,
      CSR_BRIGHT_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAT_W-1:0] sat_limit;
      logic [LIM_W-1:0] dark_limit;
      logic [LIM_W-1:0] bright_limit;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0]  rem;
      logic [CH_W-1:0]  div;
      logic [CELLS-1:0] acc;
   } lane_type;

   typedef struct packed {
      lane_type        hue;
      lane_type        sat;
      logic [CH_W-1:0] brightness;
      class_type       color_class;
   } cell_data_type;

   // One restoring division step: the next dividend bit leaves the top of acc,
   // and the quotient bit enters at its bottom.
   function automatic lane_type div_step(input lane_type lane);
      lane_type      res;
      logic [CH_W:0] trial;
      logic          ge;
      trial = {lane.rem, lane.acc[CELLS-1]};
      ge = (lane.div != '0) && (trial >= {1'b0, lane.div});
      res.div = lane.div;
      res.rem = ge ? CH_W'(trial - {1'b0, lane.div}) : trial[CH_W-1:0];
      res.acc = {lane.acc[CELLS-2:0], ge};
      return res;
   endfunction

endpackage

FILE: hdl/rhc_front.sv
`timescale 1ns / 1ps
// Input stage: max, min, hue numerator, class decision and divider setup.
// Depends on rhc_pkg.
module rhc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [rhc_pkg::CH_W-1:0]  red,
   input  logic [rhc_pkg::CH_W-1:0]  green,
   input  logic [rhc_pkg::CH_W-1:0]  blue,
   input  rhc_pkg::cfg_type          cfg,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rhc_pkg::cell_data_type    out_data
);
   import rhc_pkg::*;

   logic                  valid_ff;
   cell_data_type         data_ff;
   cell_data_type         data_in;
   logic [CH_W-1:0]       mx;
   logic [CH_W-1:0]       mn;
   logic [CH_W-1:0]       delta;
   logic [NUM_W-1:0]      d17;
   logic [NUM_W-1:0]      num;
   logic [2*CH_W-1:0]     sat_num;
   logic [2*CH_W-1:0]     lim_prod;
   logic                  achrom;
   class_type             cls;
   logic [DIV_W-1:0]      hue_dvd;
   logic [DIV_W-1:0]      sat_dvd;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
      d17 = NUM_W'(delta);

      if (mx == red) begin
         if (green >= blue) begin
            num = NUM_W'(green - blue) * NUM_W'(60);
         end else begin
            num = d17 * NUM_W'(360) - NUM_W'(blue - green) * NUM_W'(60);
         end
      end else if (mx == green) begin
         num = d17 * NUM_W'(120) + NUM_W'(blue) * NUM_W'(60) - NUM_W'(red) * NUM_W'(60);
      end else begin
         num = d17 * NUM_W'(240) + NUM_W'(red) * NUM_W'(60) - NUM_W'(green) * NUM_W'(60);
      end
      if (delta == '0) num = '0;

      sat_num = {delta, {CH_W{1'b0}}} - (2*CH_W)'(delta);
      lim_prod = (2*CH_W)'(cfg.sat_limit) * (2*CH_W)'(mx);
      if (mx == '0) begin
         achrom = cfg.sat_limit != '0;
      end else begin
         achrom = sat_num < lim_prod;
      end

      if (achrom) begin
         if (LIM_W'(mx) < cfg.dark_limit) cls = CLASS_BLACK;
         else if (LIM_W'(mx) >= cfg.bright_limit) cls = CLASS_WHITE;
         else cls = CLASS_GRAY;
      end else if (num < d17 * NUM_W'(30) || num >= d17 * NUM_W'(330)) begin
         cls = CLASS_RED;
      end else if (num < d17 * NUM_W'(60)) begin
         cls = CLASS_ORANGE;
      end else if (num < d17 * NUM_W'(90)) begin
         cls = CLASS_YELLOW;
      end else if (num < d17 * NUM_W'(150)) begin
         cls = CLASS_GREEN;
      end else if (num < d17 * NUM_W'(210)) begin
         cls = CLASS_CYAN;
      end else if (num < d17 * NUM_W'(270)) begin
         cls = CLASS_BLUE;
      end else begin
         cls = CLASS_MAGENTA;
      end

      // The quotient fits in CELLS bits, so the part above them is below the divisor.
      hue_dvd = DIV_W'(num) << HUE_FRAC_BITS;
      sat_dvd = DIV_W'(sat_num);

      data_in.hue.rem = hue_dvd[DIV_W-1 -: CH_W];
      data_in.hue.div = delta;
      data_in.hue.acc = hue_dvd[CELLS-1:0];
      data_in.sat.rem = sat_dvd[DIV_W-1 -: CH_W];
      data_in.sat.div = mx;
      data_in.sat.acc = sat_dvd[CELLS-1:0];
      data_in.brightness = mx;
      data_in.color_class = cls;
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/rhc_cell.sv
`timescale 1ns / 1ps
// One cell of the divider chain: a quotient bit of hue and of saturation per beat.
// Depends on rhc_pkg.
module rhc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rhc_pkg::cell_data_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rhc_pkg::cell_data_type out_data
);
   import rhc_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in;

   always_comb begin
      data_in = in_data;
      data_in.hue = div_step(in_data.hue);
      data_in.sat = div_step(in_data.sat);
   end

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/rgb_to_hsv_color_classifier.sv
`timescale 1ns / 1ps
// Top level of the RGB to HSV converter and color classifier.
// Depends on rhc_pkg, rhc_front and rhc_cell.
//
// One pixel is accepted per clock while the output takes results, and every
// pixel gives one result beat. One input stage finds max, min, the hue
// numerator and the class, then a chain of CELLS identical cells performs
// both divisions, one quotient bit per cell. Each stage holds its beat when
// the next one is full, so bubbles close up and new pixels keep entering
// while a result waits at the output, until every stage is full. The user must write
// thresholds through the csr port only while no pixel is in flight; the block does not enforce it.
module rgb_to_hsv_color_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [rhc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // hue_fixed [14:0], saturation [22:15], brightness [30:23],
   // color_class [34:31], zeros above
   output logic [rhc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [rhc_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [rhc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rhc_pkg::*;

   logic [SAT_W-1:0] sat_limit_ff;
   logic [LIM_W-1:0] dark_limit_ff;
   logic [LIM_W-1:0] bright_limit_ff;
   cfg_type          cfg;

   logic             stage_valid [CELLS+1];
   logic             stage_ready [CELLS+1];
   cell_data_type    stage_data  [CELLS+1];

   cell_data_type    last;
   logic [HUE_W-1:0] rsp_hue;
   logic [SAT_W-1:0] rsp_sat;
   logic [CH_W-1:0]  rsp_bright;
   class_type        rsp_class;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_limit_ff <= SAT_LIMIT_RESET;
         dark_limit_ff <= DARK_LIMIT_RESET;
         bright_limit_ff <= BRIGHT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SAT_LIMIT:    sat_limit_ff <= csr_wdata[SAT_W-1:0];
            CSR_DARK_LIMIT:   dark_limit_ff <= csr_wdata[LIM_W-1:0];
            CSR_BRIGHT_LIMIT: bright_limit_ff <= csr_wdata[LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.sat_limit = sat_limit_ff;
   assign cfg.dark_limit = dark_limit_ff;
   assign cfg.bright_limit = bright_limit_ff;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .cfg       (cfg),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      rhc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   assign stage_ready[CELLS] = rsp_tready;
   assign rsp_tvalid = stage_valid[CELLS];
   assign last = stage_data[CELLS];

   assign rsp_hue = last.hue.acc[HUE_W-1:0];
   assign rsp_sat = last.sat.acc[SAT_W-1:0];
   assign rsp_bright = last.brightness;
   assign rsp_class = last.color_class;
   assign rsp_tdata = RSP_DATA_W'({rsp_class, rsp_bright, rsp_sat, rsp_hue});

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled although the output stage is empty");

   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_bright == '0 |-> rsp_sat == '0)
      else $error("nonzero saturation for a black pixel");

   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_sat == '0 |-> rsp_hue == '0)
      else $error("nonzero hue for a pixel without saturation");

   a_black_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_class == CLASS_BLACK |-> LIM_W'(rsp_bright) < dark_limit_ff)
      else $error("black class above the dark limit");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_to_hsv_color_classifier: drives pixels, predicts HSV and
// color class for every accepted beat, and compares each result beat in order.
// Depends on rhc_pkg and the rgb_to_hsv_color_classifier RTL.
module tb_top;
   import rhc_pkg::*;

   localparam int PIPE_LATENCY = 1 + CELLS;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      class_type          cls;
      logic [CH_W-1:0]    bright;
      logic [SAT_W-1:0]   sat;
      logic [HUE_W-1:0]   hue;
   } hsv_pixel_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_W-1:0]     req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_W-1:0]     rsp_tdata;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_addr;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   logic [SAT_W-1:0] sat_limit_q;
   logic [LIM_W-1:0] dark_limit_q;
   logic [LIM_W-1:0] bright_limit_q;

   hsv_pixel_type predicted_hsv[$];
   int mismatch_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   rgb_to_hsv_color_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("rgb_to_hsv_color_classifier regression: fail");
      $finish;
   end

   function automatic hsv_pixel_type convert_pixel(input logic [CH_W-1:0] r8, g8, b8);
      hsv_pixel_type res;
      int unsigned r, g, b, mx, mn, delta, num, sat, sat_lim;
      longint unsigned hue_q;
      logic achromatic;
      r = r8;
      g = g8;
      b = b8;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      num = 0;
      hue_q = 0;
      sat = 0;
      sat_lim = sat_limit_q;
      if (mx != 0) sat = (255 * delta) / mx;
      // The hue in degrees is num / delta, kept as a fraction so sector bounds compare exactly.
      if (delta != 0) begin
         if (mx == r) begin
            if (g >= b) num = 60 * (g - b);
            else num = 360 * delta - 60 * (b - g);
         end else if (mx == g) begin
            num = 120 * delta + 60 * b - 60 * r;
         end else begin
            num = 240 * delta + 60 * r - 60 * g;
         end
         hue_q = (longint'(num) << HUE_FRAC_BITS) / delta;
      end
      if (mx == 0) achromatic = (sat_lim > 0);
      else achromatic = (255 * delta < sat_lim * mx);
      if (achromatic) begin
         if (mx < dark_limit_q) res.cls = CLASS_BLACK;
         else if (mx >= bright_limit_q) res.cls = CLASS_WHITE;
         else res.cls = CLASS_GRAY;
      end else if (num < 30 * delta || num >= 330 * delta) res.cls = CLASS_RED;
      else if (num < 60 * delta) res.cls = CLASS_ORANGE;
      else if (num < 90 * delta) res.cls = CLASS_YELLOW;
      else if (num < 150 * delta) res.cls = CLASS_GREEN;
      else if (num < 210 * delta) res.cls = CLASS_CYAN;
      else if (num < 270 * delta) res.cls = CLASS_BLUE;
      else res.cls = CLASS_MAGENTA;
      res.hue = hue_q[HUE_W-1:0];
      res.sat = sat[SAT_W-1:0];
      res.bright = mx[CH_W-1:0];
      return res;
   endfunction

   task automatic note_mismatch(input string field, input int unsigned want_v, got_v);
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
   endtask

   always @(posedge clock) begin : check_beats
      hsv_pixel_type want;
      hsv_pixel_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = hsv_pixel_type'(rsp_tdata[RSP_BITS-1:0]);
            if (predicted_hsv.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected result beat, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = predicted_hsv.pop_front();
               if (got.hue !== want.hue) note_mismatch("hue_fixed", want.hue, got.hue);
               if (got.sat !== want.sat) note_mismatch("saturation", want.sat, got.sat);
               if (got.bright !== want.bright)
                  note_mismatch("brightness", want.bright, got.bright);
               if (got.cls !== want.cls) note_mismatch("color_class", want.cls, got.cls);
            end
         end
         if (req_tvalid && req_tready)
            predicted_hsv.push_back(convert_pixel(req_tdata[7:0], req_tdata[15:8],
                                                  req_tdata[23:16]));
      end
   end

   function automatic int draw_wait(input int pct);
      return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 14)) : 0;
   endfunction

   initial begin : result_sink
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = draw_wait(rsp_idle_pct);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
      int gap;
      gap = draw_wait(req_idle_pct);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {b, g, r};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   function automatic logic [CH_W-1:0] clamp_channel(input int v);
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[CH_W-1:0];
   endfunction

   task automatic send_random_pixel();
      int pick, base;
      logic [CH_W-1:0] r, g, b;
      pick = $urandom_range(0, 99);
      r = CH_W'($urandom);
      g = CH_W'($urandom);
      b = CH_W'($urandom);
      if (pick < 20) begin
         // Near-gray pixels sit on the achromatic threshold.
         base = $urandom_range(0, 255);
         r = clamp_channel(base + int'($urandom_range(0, 20)) - 10);
         g = clamp_channel(base + int'($urandom_range(0, 20)) - 10);
         b = clamp_channel(base + int'($urandom_range(0, 20)) - 10);
      end else if (pick < 35) begin
         case ($urandom_range(0, 2))
            0: g = r;
            1: b = g;
            default: b = r;
         endcase
      end else if (pick < 45) begin
         if ($urandom_range(0, 1)) r = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
         if ($urandom_range(0, 1)) g = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
         if ($urandom_range(0, 1)) b = ($urandom_range(0, 1)) ? 8'd255 : 8'd0;
      end else if (pick < 60) begin
         r = CH_W'($urandom_range(0, 15));
         g = CH_W'($urandom_range(0, 15));
         b = CH_W'($urandom_range(0, 15));
      end
      send_pixel(r, g, b);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (predicted_hsv.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SAT_LIMIT:    sat_limit_q = value[SAT_W-1:0];
         CSR_DARK_LIMIT:   dark_limit_q = value[LIM_W-1:0];
         CSR_BRIGHT_LIMIT: bright_limit_q = value[LIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_limits(input logic [CSR_DATA_W-1:0] sat_v, dark_v, bright_v);
      write_csr(CSR_SAT_LIMIT, sat_v);
      write_csr(CSR_DARK_LIMIT, dark_v);
      write_csr(CSR_BRIGHT_LIMIT, bright_v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_pixels();
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      send_pixel(0, 0, 0);
      send_pixel(255, 255, 255);
      send_pixel(76, 76, 76);
      send_pixel(77, 77, 77);
      send_pixel(178, 178, 178);
      send_pixel(179, 179, 179);
      send_pixel(255, 0, 0);
      send_pixel(0, 255, 0);
      send_pixel(0, 0, 255);
      send_pixel(2, 1, 0);
      send_pixel(1, 1, 0);
      send_pixel(1, 2, 0);
      send_pixel(0, 2, 1);
      send_pixel(0, 1, 2);
      send_pixel(1, 0, 2);
      send_pixel(2, 0, 1);
      send_pixel(255, 127, 0);
      send_pixel(0, 255, 255);
      send_pixel(255, 0, 255);
      send_pixel(100, 80, 80);
      send_pixel(100, 81, 81);
      send_pixel(255, 254, 253);
      send_pixel(1, 0, 0);
      wait_for_results();
   endtask

   task automatic test_threshold_settings();
      logic [CSR_DATA_W-1:0] settings[8][3];
      settings = '{
         '{9'd0,   9'd0,   9'd0},
         '{9'h1FF, 9'd511, 9'd511},
         '{9'd255, 9'd256, 9'd256},
         '{9'h100, 9'd256, 9'd0},
         '{9'd255, 9'd0,   9'd256},
         '{9'd1,   9'd128, 9'd129},
         '{9'd128, 9'd100, 9'd200},
         '{9'd51,  9'd77,  9'd179}
      };
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      foreach (settings[i]) begin
         apply_limits(settings[i][0], settings[i][1], settings[i][2]);
         if (i == 2) begin
            write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
            @(negedge clock);
            csr_we <= 1'b0;
         end
         send_pixel(0, 0, 0);
         send_pixel(255, 255, 255);
         repeat (45) send_random_pixel();
         wait_for_results();
      end
   endtask

   task automatic test_random_traffic();
      int idle_modes[6][2];
      idle_modes = '{'{0, 0}, '{100, 0}, '{0, 100}, '{50, 50}, '{100, 100}, '{10, 70}};
      foreach (idle_modes[i]) begin
         req_idle_pct = idle_modes[i][0];
         rsp_idle_pct = idle_modes[i][1];
         if (i == 0) apply_limits(9'd51, 9'd77, 9'd179);
         else apply_limits(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(0, 300)),
                           CSR_DATA_W'($urandom_range(0, 300)));
         repeat (210) send_random_pixel();
         wait_for_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      sat_limit_q = SAT_LIMIT_RESET;
      dark_limit_q = DARK_LIMIT_RESET;
      bright_limit_q = BRIGHT_LIMIT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_pixels();
      test_threshold_settings();
      test_random_traffic();

      if (mismatch_count == 0)
         $display("rgb_to_hsv_color_classifier regression: pass");
      else
         $display("rgb_to_hsv_color_classifier regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_cell.sv
hdl/rgb_to_hsv_color_classifier.sv
tb/sv/tb_top.sv
